/* rtl/mfsd_pkg.sv */
// Package: shared types and constants for the framebuffer shape draw unit.
package mfsd_pkg;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned AddrW      = 10;

  typedef enum logic [3:0] {
    OP_PIXEL  = 4'd0,
    OP_HLINE  = 4'd1,
    OP_VLINE  = 4'd2,
    OP_RECT   = 4'd3,
    OP_FRECT  = 4'd4,
    OP_CIRC   = 4'd5,
    OP_FCIRC  = 4'd6,
    OP_CLEAR  = 4'd7,
    OP_READ   = 4'd8
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SPAN_LOAD,
    ST_RD,
    ST_WAIT,
    ST_WR,
    ST_CIRC_INIT,
    ST_CIRC_STEP,
    ST_RDREQ,
    ST_RDWAIT,
    ST_OUT
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       latch;      // capture the input word
    logic       clr_init;   // reset clear counter
    logic       clr_write;  // write zero at clear counter, advance
    logic       span_load;  // load span generator from current span list slot
    logic       px_read;    // issue store read for current pixel
    logic       px_write;   // write modified byte, advance pixel
    logic       circ_init;  // initialize circle variables
    logic       circ_step;  // advance circle by one octant step
    logic       rd_req;     // issue store read at byte index
    logic       rd_cap;     // capture read data
  } ctrl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic       clr_done;   // last clear address written
    logic       span_empty; // current span has no pixels
    logic       span_last;  // current pixel is last of the span
    logic       slot_last;  // span list slot is the last one for this pass
    logic       circ_done;  // circle loop finished
    logic       is_circle;  // command runs the circle loop
  } stat_t;

endpackage

/* rtl/mono_framebuffer_shape_draw_unit.sv */
// Top level: framebuffer shape draw unit.
// Drawing engine for a page-organized 1-bit framebuffer (8 vertical pixels a byte).
// Input channel (in_valid_i/in_ready_o) takes one command word: opcode, coordinates,
// spans, radius, pixel_on and byte_index. Output channel (out_valid_o/out_ready_i)
// returns read_data only for the read command.
// Each plotted pixel is a read-modify-write on the single port frame store (read,
// wait, write states), and each span is loaded first; a circle also runs a step state.
// Clear writes one byte a cycle over all 1024 bytes; a read issues the store read,
// captures the byte and then presents it.
// After reset the block runs the same clearing pass and accepts no command
// until it ends. While a read result waits for out_ready_i the block holds it and
// takes no new command. Commands are processed one at a time.
// Out-of-range opcodes are accepted and dropped.
module mono_framebuffer_shape_draw_unit #(
  parameter int unsigned DISPLAY_WIDTH  = 128,
  parameter int unsigned DISPLAY_HEIGHT = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] opcode_i,
  input  logic [7:0] x_coord_i,
  input  logic [7:0] y_coord_i,
  input  logic [7:0] span_width_i,
  input  logic [7:0] span_height_i,
  input  logic [7:0] radius_i,
  input  logic       pixel_on_i,
  input  logic [9:0] byte_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o
);
  mfsd_pkg::ctrl_t ctrl;
  mfsd_pkg::stat_t stat;

  mfsd_datapath #(.DisplayWidth(DISPLAY_WIDTH), .DisplayHeight(DISPLAY_HEIGHT)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .opcode_i, .x_coord_i, .y_coord_i, .span_width_i, .span_height_i,
    .radius_i, .pixel_on_i, .byte_index_i, .read_data_o
  );

  mfsd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i,
    .out_valid_o, .out_ready_i, .stat_i(stat), .ctrl_o(ctrl)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.clr_write, ctrl.px_write, ctrl.rd_req, ctrl.px_read}))
    else $error("conflicting store commands");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o))
    else $error("result dropped");
`endif
endmodule

/* rtl/mfsd_ram.sv */
// Generic single port RAM with registered read.
module mfsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* rtl/mfsd_datapath.sv */
// Datapath: span generator, circle stepper, address math and frame store.
module mfsd_datapath #(
  parameter int unsigned DisplayWidth  = 128,
  parameter int unsigned DisplayHeight = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mfsd_pkg::ctrl_t    ctrl_i,
  output mfsd_pkg::stat_t    stat_o,
  input  logic [3:0]         opcode_i,
  input  logic [7:0]         x_coord_i,
  input  logic [7:0]         y_coord_i,
  input  logic [7:0]         span_width_i,
  input  logic [7:0]         span_height_i,
  input  logic [7:0]         radius_i,
  input  logic               pixel_on_i,
  input  logic [9:0]         byte_index_i,
  output logic [7:0]         read_data_o
);
  localparam int unsigned AW = mfsd_pkg::AddrW;

  logic [3:0] op_q;
  logic [7:0] x_q, y_q, w_q, h_q, r_q;
  logic       on_q;
  logic [9:0] idx_q;

  // Span generator: current pixel, direction, length, column count (filled rect).
  logic [7:0] slen_q, cnt_q;
  logic       svert_q;
  logic [7:0] px_x_q, px_y_q;
  logic [2:0] slot_q;
  logic [7:0] col_q;  // filled rect column

  // Circle: signed 11 bit error terms, unsigned 9 bit offsets.
  logic signed [10:0] f_q, ddx_q, ddy_q;
  logic [8:0]         a_q, b_q;
  logic               cfirst_q;

  logic [AW-1:0] clr_q;

  // RAM port.
  logic          we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    wdata, rdata;

  // Pixel address for current pixel.
  logic        px_ok;
  logic [15:0] px_full;
  logic [AW-1:0] px_addr;
  logic [7:0]  bitmask;
  always_comb begin
    px_full = 16'(px_x_q) + 16'(px_y_q >> 3) * 16'(DisplayWidth);
    px_ok   = (32'(px_x_q) < DisplayWidth) && (32'(px_y_q) < DisplayHeight) &&
              (px_full < 16'(mfsd_pkg::StoreDepth));
    px_addr = px_full[AW-1:0];
    bitmask = 8'd1 << px_y_q[2:0];
  end

  always_comb begin
    we       = 1'b0;
    ram_addr = px_addr;
    wdata    = on_q ? (rdata | bitmask) : (rdata & ~bitmask);
    if (ctrl_i.clr_write) begin
      we = 1'b1; ram_addr = clr_q; wdata = 8'd0;
    end else if (ctrl_i.rd_req) begin
      ram_addr = idx_q;
    end else if (ctrl_i.px_write) begin
      we = px_ok;
    end
  end

  mfsd_ram #(.Width(8), .Depth(mfsd_pkg::StoreDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (ram_addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // Span slot table: start, direction and length for the current slot.
  logic [7:0] ns_x, ns_y, ns_len;
  logic       ns_vert;
  logic [7:0] ca, cb, na, nb, two_a1, two_b1;
  always_comb begin
    ca = a_q[7:0];
    cb = b_q[7:0];
    two_a1 = {ca[6:0], 1'b1};
    two_b1 = {cb[6:0], 1'b1};
    ns_x = x_q; ns_y = y_q; ns_len = 8'd1; ns_vert = 1'b0;
    na = 8'd0 - ca;
    nb = 8'd0 - cb;
    unique case (mfsd_pkg::opcode_e'(op_q))
      mfsd_pkg::OP_HLINE: ns_len = w_q;
      mfsd_pkg::OP_VLINE: begin ns_len = h_q; ns_vert = 1'b1; end
      mfsd_pkg::OP_RECT: begin
        unique case (slot_q[1:0])
          2'd0: ns_len = w_q;
          2'd1: begin ns_y = y_q + h_q - 8'd1; ns_len = w_q; end
          2'd2: begin ns_len = h_q; ns_vert = 1'b1; end
          default: begin ns_x = x_q + w_q - 8'd1; ns_len = h_q; ns_vert = 1'b1; end
        endcase
      end
      mfsd_pkg::OP_FRECT: begin
        // zero width draws no column at all
        ns_x = x_q + col_q; ns_len = (w_q == 8'd0) ? 8'd0 : h_q; ns_vert = 1'b1;
      end
      mfsd_pkg::OP_CIRC: begin
        ns_len = 8'd1;
        if (cfirst_q) begin
          unique case (slot_q[1:0])
            2'd0: ns_y = y_q + cb;
            2'd1: ns_y = y_q + nb;
            2'd2: ns_x = x_q + cb;
            default: ns_x = x_q + nb;
          endcase
        end else begin
          unique case (slot_q)
            3'd0: begin ns_x = x_q + ca; ns_y = y_q + cb; end
            3'd1: begin ns_x = x_q + na; ns_y = y_q + cb; end
            3'd2: begin ns_x = x_q + ca; ns_y = y_q + nb; end
            3'd3: begin ns_x = x_q + na; ns_y = y_q + nb; end
            3'd4: begin ns_x = x_q + cb; ns_y = y_q + ca; end
            3'd5: begin ns_x = x_q + nb; ns_y = y_q + ca; end
            3'd6: begin ns_x = x_q + cb; ns_y = y_q + na; end
            default: begin ns_x = x_q + nb; ns_y = y_q + na; end
          endcase
        end
      end
      mfsd_pkg::OP_FCIRC: begin
        unique case (slot_q[1:0])
          2'd0: begin ns_x = x_q + na; ns_y = y_q + nb; ns_len = two_a1; end
          2'd1: begin ns_x = x_q + na; ns_y = y_q + cb; ns_len = two_a1; end
          2'd2: begin ns_x = x_q + nb; ns_y = y_q + na; ns_len = two_b1; end
          default: begin ns_x = x_q + nb; ns_y = y_q + ca; ns_len = two_b1; end
        endcase
      end
      default: ns_len = 8'd1;
    endcase
  end

  // Circle step values.
  logic signed [10:0] f_n, ddx_n, ddy_n, fd_n;
  logic [8:0]         a_n, b_n, ab_diff;

  always_comb begin
    stat_o.clr_done   = (clr_q == AW'(mfsd_pkg::StoreDepth - 1));
    stat_o.span_empty = (ns_len == 8'd0);
    stat_o.span_last  = (cnt_q == slen_q - 8'd1);
    stat_o.is_circle  = (op_q == mfsd_pkg::OP_CIRC) || (op_q == mfsd_pkg::OP_FCIRC);
    unique case (mfsd_pkg::opcode_e'(op_q))
      mfsd_pkg::OP_RECT:  stat_o.slot_last = (slot_q == 3'd3);
      mfsd_pkg::OP_FRECT: stat_o.slot_last = (col_q == w_q - 8'd1) || (w_q == 8'd0);
      mfsd_pkg::OP_CIRC:  stat_o.slot_last = cfirst_q ? (slot_q == 3'd3) : (slot_q == 3'd7);
      mfsd_pkg::OP_FCIRC: stat_o.slot_last = (slot_q == 3'd3);
      default:            stat_o.slot_last = 1'b1;
    endcase
    // Outline tests the current point; the filled form tests the stepped point.
    if (op_q == mfsd_pkg::OP_CIRC) stat_o.circ_done = !(a_q < b_q);
    else                           stat_o.circ_done = (b_n < a_n) || b_n[8];
  end

  always_comb begin
    f_n = f_q; ddx_n = ddx_q; ddy_n = ddy_q; a_n = a_q; b_n = b_q; fd_n = f_q;
    ab_diff = '0;
    if (op_q == mfsd_pkg::OP_CIRC) begin
      if (!f_q[10]) begin
        b_n = b_q - 9'd1; ddy_n = ddy_q + 11'sd2; fd_n = f_q + ddy_n;
      end
      a_n = a_q + 9'd1; ddx_n = ddx_q + 11'sd2; f_n = fd_n + ddx_n;
    end else begin
      a_n = a_q + 9'd1;
      if (f_q[10]) begin
        f_n = f_q + $signed({1'b0, a_n, 1'b1});
      end else begin
        b_n = b_q - 9'd1;
        ab_diff = a_n - b_n;
        f_n = f_q + $signed({ab_diff[8], ab_diff, 1'b1});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl_i.clr_init) begin
      clr_q <= '0;
    end else if (ctrl_i.clr_write) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // Payload registers; no reset.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      op_q <= opcode_i; x_q <= x_coord_i; y_q <= y_coord_i; w_q <= span_width_i;
      h_q <= span_height_i; r_q <= radius_i; on_q <= pixel_on_i; idx_q <= byte_index_i;
      slot_q <= 3'd0; col_q <= 8'd0; cfirst_q <= 1'b1;
      a_q <= 9'd0; b_q <= {1'b0, radius_i};
    end
    if (ctrl_i.circ_init) begin
      a_q <= 9'd0; b_q <= {1'b0, r_q}; ddx_q <= 11'sd1;
      f_q <= 11'sd1 - $signed({3'd0, r_q});
      ddy_q <= -$signed({2'd0, r_q, 1'b0});
      cfirst_q <= (op_q == mfsd_pkg::OP_CIRC);
      slot_q <= 3'd0;
    end
    if (ctrl_i.circ_step) begin
      a_q <= a_n; b_q <= b_n; f_q <= f_n; ddx_q <= ddx_n; ddy_q <= ddy_n;
      cfirst_q <= 1'b0; slot_q <= 3'd0;
    end
    if (ctrl_i.span_load) begin
      slen_q <= ns_len; svert_q <= ns_vert;
      px_x_q <= ns_x; px_y_q <= ns_y; cnt_q <= 8'd0;
    end
    if (ctrl_i.px_write) begin
      cnt_q <= cnt_q + 8'd1;
      if (svert_q) px_y_q <= px_y_q + 8'd1;
      else         px_x_q <= px_x_q + 8'd1;
      if (stat_o.span_last) begin
        slot_q <= slot_q + 3'd1;
        col_q  <= col_q + 8'd1;
      end
    end
    // Empty span skips to the next slot.
    if (ctrl_i.span_load && (ns_len == 8'd0)) begin
      slot_q <= slot_q + 3'd1;
      col_q  <= col_q + 8'd1;
    end
    if (ctrl_i.rd_cap) read_data_o <= rdata;
  end
endmodule

/* rtl/mfsd_ctrl.sv */
// Controller: sequences clear, span plotting, circle steps and reads.
module mfsd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [3:0]      opcode_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  mfsd_pkg::stat_t stat_i,
  output mfsd_pkg::ctrl_t ctrl_o
);
  mfsd_pkg::state_e state_q, state_d;
  logic acc;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mfsd_pkg::ST_IDLE: if (acc) begin
        priority case (opcode_i)
          mfsd_pkg::OP_CLEAR: state_d = mfsd_pkg::ST_CLEAR;
          mfsd_pkg::OP_READ:  state_d = mfsd_pkg::ST_RDREQ;
          mfsd_pkg::OP_CIRC, mfsd_pkg::OP_FCIRC: state_d = mfsd_pkg::ST_CIRC_INIT;
          mfsd_pkg::OP_PIXEL, mfsd_pkg::OP_HLINE, mfsd_pkg::OP_VLINE,
          mfsd_pkg::OP_RECT, mfsd_pkg::OP_FRECT: state_d = mfsd_pkg::ST_SPAN_LOAD;
          default: state_d = mfsd_pkg::ST_IDLE;
        endcase
      end
      mfsd_pkg::ST_CLEAR: if (stat_i.clr_done) state_d = mfsd_pkg::ST_IDLE;
      mfsd_pkg::ST_CIRC_INIT: state_d = mfsd_pkg::ST_SPAN_LOAD;
      mfsd_pkg::ST_SPAN_LOAD: begin
        if (!stat_i.span_empty) state_d = mfsd_pkg::ST_RD;
        else if (stat_i.slot_last)
          state_d = stat_i.is_circle ? mfsd_pkg::ST_CIRC_STEP : mfsd_pkg::ST_IDLE;
      end
      mfsd_pkg::ST_RD:   state_d = mfsd_pkg::ST_WAIT;
      mfsd_pkg::ST_WAIT: state_d = mfsd_pkg::ST_WR;
      mfsd_pkg::ST_WR: begin
        if (!stat_i.span_last) state_d = mfsd_pkg::ST_RD;
        else if (!stat_i.slot_last) state_d = mfsd_pkg::ST_SPAN_LOAD;
        else state_d = stat_i.is_circle ? mfsd_pkg::ST_CIRC_STEP : mfsd_pkg::ST_IDLE;
      end
      // Both forms draw before stepping; the outline tests the current point, the filled form the stepped one.
      mfsd_pkg::ST_CIRC_STEP:
        state_d = stat_i.circ_done ? mfsd_pkg::ST_IDLE : mfsd_pkg::ST_SPAN_LOAD;
      mfsd_pkg::ST_RDREQ:  state_d = mfsd_pkg::ST_RDWAIT;
      mfsd_pkg::ST_RDWAIT: state_d = mfsd_pkg::ST_OUT;
      mfsd_pkg::ST_OUT: if (out_ready_i) state_d = mfsd_pkg::ST_IDLE;
      default: state_d = mfsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    in_ready_o  = (state_q == mfsd_pkg::ST_IDLE);
    out_valid_o = (state_q == mfsd_pkg::ST_OUT);
    unique case (state_q)
      mfsd_pkg::ST_IDLE: begin
        ctrl_o.latch = acc;
        ctrl_o.clr_init = 1'b1;
      end
      mfsd_pkg::ST_CLEAR:     ctrl_o.clr_write = 1'b1;
      mfsd_pkg::ST_CIRC_INIT: ctrl_o.circ_init = 1'b1;
      mfsd_pkg::ST_SPAN_LOAD: ctrl_o.span_load = 1'b1;
      mfsd_pkg::ST_RD:        ctrl_o.px_read = 1'b1;
      mfsd_pkg::ST_WR:        ctrl_o.px_write = 1'b1;
      mfsd_pkg::ST_CIRC_STEP: ctrl_o.circ_step = !stat_i.circ_done;
      mfsd_pkg::ST_RDREQ:     ctrl_o.rd_req = 1'b1;
      mfsd_pkg::ST_RDWAIT:    ctrl_o.rd_cap = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= mfsd_pkg::ST_CLEAR;
    else         state_q <= state_d;
  end
endmodule
